// File: rtl/scs_pkg.sv
`default_nettype none

package scs_pkg;

    // Field widths.
    localparam int DelayW = 14;
    localparam int StepW  = 10;
    localparam int FuncW  = 8;
    localparam int AdcW   = 12;
    localparam int ModeW  = 4;
    localparam int CfgW   = 14;
    localparam int CfgIdxW = 2;

    // Pot scaling: delay = PotBase + adc * PotSpan / AdcFull.
    localparam int PotSpanW = 11;
    localparam int ProdW    = AdcW + PotSpanW;
    localparam logic [ProdW-1:0] PotSpan = ProdW'(1900);
    localparam logic [AdcW:0]    AdcFull = (AdcW + 1)'(4095);
    localparam logic [DelayW-1:0] PotBase = DelayW'(100);

    // Reset values and preset delays.
    localparam logic [DelayW-1:0] DefaultDelay = DelayW'(500);
    localparam logic [DelayW-1:0] PresetFast   = DelayW'(250);
    localparam logic [DelayW-1:0] PresetMid    = DelayW'(2000);
    localparam logic [DelayW-1:0] PresetSlow   = DelayW'(10000);
    localparam logic [StepW-1:0]  SlewStepRst  = StepW'(50);
    localparam logic [DelayW-1:0] MinTargetRst = DelayW'(50);
    localparam logic [DelayW-1:0] MaxTargetRst = DelayW'(4000);

    // Command codes.
    typedef enum logic [ModeW-1:0] {
        MODE_TICK      = 4'd0,
        MODE_SET_FUNC  = 4'd1,
        MODE_SOUND     = 4'd2,
        MODE_UP        = 4'd3,
        MODE_DOWN      = 4'd4,
        MODE_DEFAULT   = 4'd5,
        MODE_POT       = 4'd6,
        MODE_FAST      = 4'd7,
        MODE_MID       = 4'd8,
        MODE_SLOW      = 4'd9
    } mode_t;

    // Configuration register indexes.
    typedef enum logic [CfgIdxW-1:0] {
        CFG_SLEW_STEP  = 2'd0,
        CFG_MIN_TARGET = 2'd1,
        CFG_MAX_TARGET = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [DelayW-1:0] current_delay;
        logic [DelayW-1:0] target_delay;
        logic [FuncW-1:0]  active_function;
        logic              sound;
        logic              smoothing;
    } state_t;

    typedef struct packed {
        logic [StepW-1:0]  slew_step;
        logic [DelayW-1:0] min_target;
        logic [DelayW-1:0] max_target;
    } cfg_t;

endpackage

`default_nettype wire

// File: rtl/scs_update.sv
`default_nettype none

module scs_update (
    input  scs_pkg::state_t               state,
    input  scs_pkg::cfg_t                 cfg,
    input  logic [scs_pkg::ModeW-1:0]     mode,
    input  logic [scs_pkg::FuncW-1:0]     value,
    input  logic [scs_pkg::ProdW-1:0]     pot_product,
    output scs_pkg::state_t               state_next,
    output logic                          changed
);
    import scs_pkg::*;

    logic [DelayW-1:0]   diff_up;
    logic [DelayW-1:0]   diff_down;
    logic [DelayW-1:0]   tick_delay;
    logic [DelayW-1:0]   halved;
    logic [DelayW-1:0]   halved_floor;
    logic [DelayW:0]     doubled;
    logic [DelayW-1:0]   doubled_cap;
    logic [PotSpanW-1:0] prod_hi;
    logic [AdcW:0]       prod_sum;
    logic [PotSpanW-1:0] pot_quot;
    logic [DelayW-1:0]   pot_delay;

    // One slew step toward the target, landing on it when the gap is small.
    assign diff_up   = state.target_delay - state.current_delay;
    assign diff_down = state.current_delay - state.target_delay;

    always_comb
    begin
        tick_delay = state.current_delay;
        if (state.current_delay < state.target_delay)
        begin
            if (diff_up <= DelayW'(cfg.slew_step))
                tick_delay = state.target_delay;
            else
                tick_delay = state.current_delay + DelayW'(cfg.slew_step);
        end
        else if (state.current_delay > state.target_delay)
        begin
            if (diff_down <= DelayW'(cfg.slew_step))
                tick_delay = state.target_delay;
            else
                tick_delay = state.current_delay - DelayW'(cfg.slew_step);
        end
    end

    // Halve with a floor, double with a cap.
    assign halved       = state.target_delay >> 1;
    assign halved_floor = (halved < cfg.min_target) ? cfg.min_target : halved;
    assign doubled      = {state.target_delay, 1'b0};
    assign doubled_cap  = (doubled > {1'b0, cfg.max_target}) ?
                          cfg.max_target : doubled[DelayW-1:0];

    // Division by 4095: with p = hi * 4096 + lo, p / 4095 is hi, plus one
    // when hi + lo reaches 4095 (the sum stays below twice the divisor).
    assign prod_hi   = pot_product[ProdW-1:AdcW];
    assign prod_sum  = (AdcW + 1)'(prod_hi) + {1'b0, pot_product[AdcW-1:0]};
    assign pot_quot  = prod_hi + PotSpanW'(prod_sum >= AdcFull);
    assign pot_delay = PotBase + DelayW'(pot_quot);

    // Command decode.
    always_comb
    begin
        state_next = state;
        changed    = 1'b0;
        case (mode)
            MODE_TICK:
            begin
                if (state.smoothing)
                    state_next.current_delay = tick_delay;
            end
            MODE_SET_FUNC:
            begin
                state_next.active_function = value;
                changed = 1'b1;
            end
            MODE_SOUND:
            begin
                state_next.sound = ~state.sound;
            end
            MODE_UP:
            begin
                state_next.target_delay = halved_floor;
                state_next.smoothing    = 1'b1;
            end
            MODE_DOWN:
            begin
                state_next.target_delay = doubled_cap;
                state_next.smoothing    = 1'b1;
            end
            MODE_DEFAULT:
            begin
                state_next.target_delay = DefaultDelay;
                state_next.smoothing    = 1'b1;
            end
            MODE_POT:
            begin
                state_next.current_delay = pot_delay;
                state_next.target_delay  = pot_delay;
                state_next.smoothing     = 1'b0;
            end
            MODE_FAST:
            begin
                state_next.target_delay = PresetFast;
                state_next.smoothing    = 1'b1;
            end
            MODE_MID:
            begin
                state_next.target_delay = PresetMid;
                state_next.smoothing    = 1'b1;
            end
            MODE_SLOW:
            begin
                state_next.target_delay = PresetSlow;
                state_next.smoothing    = 1'b1;
            end
            default:
            begin
                state_next = state;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/speed_command_slew_controller.sv
// Accepted items enter the command register, and a single decode and update
// stage writes the state and the result register. Throughput: one item per
// cycle while out_stall is low.
// Reset (rst_n, asynchronous, active low): both delays 500, function 0,
// sound and smoothing on, slew step 50, floor 50, cap 4000, pipeline empty.
`default_nettype none

module speed_command_slew_controller (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [scs_pkg::ModeW-1:0]     mode,
    input  logic [scs_pkg::FuncW-1:0]     value,
    input  logic [scs_pkg::AdcW-1:0]      adc_sample,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [scs_pkg::DelayW-1:0]    current_delay,
    output logic [scs_pkg::DelayW-1:0]    target_delay,
    output logic [scs_pkg::FuncW-1:0]     active_function,
    output logic                          sound_enabled,
    output logic                          smoothing_enabled,
    output logic                          function_changed,
    input  logic                          cfg_we,
    input  logic [scs_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [scs_pkg::CfgW-1:0]      cfg_data
);
    import scs_pkg::*;

    cfg_t               cfg_reg;
    state_t             state_reg;
    state_t             state_next;
    logic               changed_next;

    logic               cmd_valid_reg;
    logic [ModeW-1:0]   cmd_mode_reg;
    logic [FuncW-1:0]   cmd_value_reg;
    logic [ProdW-1:0]   cmd_prod_reg;

    logic               res_valid_reg;
    state_t             res_state_reg;
    logic               res_changed_reg;

    logic               res_free;
    logic               cmd_advance;
    logic               cmd_free;

    // Pipeline flow: the result register frees when empty or being taken.
    assign res_free    = ~res_valid_reg | ~out_stall;
    assign cmd_advance = cmd_valid_reg & res_free;
    assign cmd_free    = ~cmd_valid_reg | res_free;
    assign in_stall    = ~cmd_free;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slew_step  <= SlewStepRst;
            cfg_reg.min_target <= MinTargetRst;
            cfg_reg.max_target <= MaxTargetRst;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SLEW_STEP:  cfg_reg.slew_step  <= cfg_data[StepW-1:0];
                CFG_MIN_TARGET: cfg_reg.min_target <= cfg_data[DelayW-1:0];
                CFG_MAX_TARGET: cfg_reg.max_target <= cfg_data[DelayW-1:0];
                default:        cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Command register; the pot product is formed on the way in.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cmd_valid_reg <= 1'b0;
        else if (cmd_free)
            cmd_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (cmd_free && in_valid)
        begin
            cmd_mode_reg  <= mode;
            cmd_value_reg <= value;
            cmd_prod_reg  <= ProdW'(adc_sample) * PotSpan;
        end
    end

    // Decode and state update.
    scs_update u_update (
        .state       (state_reg),
        .cfg         (cfg_reg),
        .mode        (cmd_mode_reg),
        .value       (cmd_value_reg),
        .pot_product (cmd_prod_reg),
        .state_next  (state_next),
        .changed     (changed_next)
    );

    // Controller state, updated as each item moves into the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.current_delay   <= DefaultDelay;
            state_reg.target_delay    <= DefaultDelay;
            state_reg.active_function <= '0;
            state_reg.sound           <= 1'b1;
            state_reg.smoothing       <= 1'b1;
        end
        else if (cmd_advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (res_free)
            res_valid_reg <= cmd_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd_advance)
        begin
            res_state_reg   <= state_next;
            res_changed_reg <= changed_next;
        end
    end

    assign out_valid         = res_valid_reg;
    assign current_delay     = res_state_reg.current_delay;
    assign target_delay      = res_state_reg.target_delay;
    assign active_function   = res_state_reg.active_function;
    assign sound_enabled     = res_state_reg.sound;
    assign smoothing_enabled = res_state_reg.smoothing;
    assign function_changed  = res_changed_reg;

endmodule

`default_nettype wire

// File: verif/speed_command_slew_controller_tb.sv
module speed_command_slew_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import scs_pkg::*;

    // One command item as it is driven onto the input channel.
    typedef struct packed {
        logic [ModeW-1:0] mode;
        logic [FuncW-1:0] value;
        logic [AdcW-1:0]  adc;
    } command_t;

    // One status item as the block reports it.
    typedef struct packed {
        logic [DelayW-1:0] current_delay;
        logic [DelayW-1:0] target_delay;
        logic [FuncW-1:0]  active_function;
        logic              sound;
        logic              smoothing;
        logic              changed;
    } status_t;

    localparam logic [ModeW-1:0] ModeUnusedLo = 4'd10;
    localparam logic [ModeW-1:0] ModeUnusedHi = 4'd15;
    localparam int MaxPause    = 6;
    localparam int DrainCycles = 8;
    localparam int PhaseItems  = 155;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [ModeW-1:0]    mode = '0;
    logic [FuncW-1:0]    value = '0;
    logic [AdcW-1:0]     adc_sample = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [DelayW-1:0]   current_delay;
    logic [DelayW-1:0]   target_delay;
    logic [FuncW-1:0]    active_function;
    logic                sound_enabled;
    logic                smoothing_enabled;
    logic                function_changed;
    logic                cfg_we = 1'b0;
    logic [CfgIdxW-1:0]  cfg_index = '0;
    logic [CfgW-1:0]     cfg_data = '0;

    command_t    pending_cmds[$];
    status_t     expected_status[$];
    state_t      ctl_state;
    cfg_t        ctl_cfg;
    int          n_errors = 0;
    int          n_items = 0;
    int          n_ticks = 0;
    int          n_checked = 0;
    int          n_settings = 0;
    int unsigned send_wait = 0;
    int unsigned hold_wait = 0;
    bit          send_calm = 1'b0;
    bit          recv_calm = 1'b0;

    speed_command_slew_controller u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .mode              (mode),
        .value             (value),
        .adc_sample        (adc_sample),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .current_delay     (current_delay),
        .target_delay      (target_delay),
        .active_function   (active_function),
        .sound_enabled     (sound_enabled),
        .smoothing_enabled (smoothing_enabled),
        .function_changed  (function_changed),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Loads a new target and re-enables smoothing.
    function automatic void retarget(logic [DelayW-1:0] new_target);
        ctl_state.target_delay = new_target;
        ctl_state.smoothing = 1'b1;
    endfunction

    // Applies one command to the local copy of the controller state and
    // returns the status that the block should report for it.
    function automatic status_t apply_command(command_t cmd);
        logic [DelayW-1:0] gap;
        logic [DelayW-1:0] halved;
        logic [DelayW:0]   doubled;
        logic [DelayW-1:0] pot_delay;
        status_t           s;
        s.changed = 1'b0;
        case (cmd.mode)
            MODE_TICK:
                if (ctl_state.smoothing)
                begin
                    // Compare before stepping so that the delay lands on the target.
                    if (ctl_state.current_delay < ctl_state.target_delay)
                    begin
                        gap = ctl_state.target_delay - ctl_state.current_delay;
                        ctl_state.current_delay = (gap <= ctl_cfg.slew_step) ?
                            ctl_state.target_delay : ctl_state.current_delay + ctl_cfg.slew_step;
                    end
                    else if (ctl_state.current_delay > ctl_state.target_delay)
                    begin
                        gap = ctl_state.current_delay - ctl_state.target_delay;
                        ctl_state.current_delay = (gap <= ctl_cfg.slew_step) ?
                            ctl_state.target_delay : ctl_state.current_delay - ctl_cfg.slew_step;
                    end
                end
            MODE_SET_FUNC:
            begin
                ctl_state.active_function = cmd.value;
                s.changed = 1'b1;
            end
            MODE_SOUND:
                ctl_state.sound = ~ctl_state.sound;
            MODE_UP:
            begin
                halved = ctl_state.target_delay >> 1;
                if (halved < ctl_cfg.min_target)
                    halved = ctl_cfg.min_target;
                retarget(halved);
            end
            MODE_DOWN:
            begin
                // The doubled value is one bit wider, so the cap is applied before any wrap.
                doubled = {ctl_state.target_delay, 1'b0};
                if (doubled > {1'b0, ctl_cfg.max_target})
                    retarget(ctl_cfg.max_target);
                else
                    retarget(doubled[DelayW-1:0]);
            end
            MODE_DEFAULT:
                retarget(DefaultDelay);
            MODE_POT:
            begin
                pot_delay = PotBase +
                    DelayW'((int'(cmd.adc) * int'(PotSpan)) / int'(AdcFull));
                ctl_state.current_delay = pot_delay;
                ctl_state.target_delay = pot_delay;
                ctl_state.smoothing = 1'b0;
            end
            MODE_FAST:
                retarget(PresetFast);
            MODE_MID:
                retarget(PresetMid);
            MODE_SLOW:
                retarget(PresetSlow);
            default:
                ;
        endcase
        s.current_delay = ctl_state.current_delay;
        s.target_delay = ctl_state.target_delay;
        s.active_function = ctl_state.active_function;
        s.sound = ctl_state.sound;
        s.smoothing = ctl_state.smoothing;
        return s;
    endfunction

    // Draws a pause length; now and then flips into or out of a stretch without pauses.
    function automatic int unsigned draw_pause(inout bit calm);
        if ($urandom_range(0, 31) == 0)
            calm = ~calm;
        return calm ? 0 : $urandom_range(0, MaxPause);
    endfunction

    function automatic void compare_field(string field, logic [DelayW-1:0] want,
                                          logic [DelayW-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            n_errors++;
        end
    endfunction

    function automatic void queue_command(logic [ModeW-1:0] m, logic [FuncW-1:0] v,
                                          logic [AdcW-1:0] a);
        pending_cmds.push_back({m, v, a});
    endfunction

    // Random commands, with runs of ticks so that the current delay reaches far targets.
    function automatic void queue_random(int count);
        int               pick;
        int               added;
        int               run_len;
        logic [ModeW-1:0] cmd;
        added = 0;
        while (added < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                run_len = $urandom_range(5, 40);
                for (int i = 0; i < run_len; i++)
                    queue_command(MODE_TICK, FuncW'($urandom_range(0, 255)),
                                  AdcW'($urandom_range(0, 4095)));
                added += run_len;
            end
            else
            begin
                if (pick < 45)
                    cmd = MODE_TICK;
                else if (pick < 52)
                    cmd = MODE_SET_FUNC;
                else if (pick < 57)
                    cmd = MODE_SOUND;
                else if (pick < 64)
                    cmd = MODE_UP;
                else if (pick < 71)
                    cmd = MODE_DOWN;
                else if (pick < 75)
                    cmd = MODE_DEFAULT;
                else if (pick < 82)
                    cmd = MODE_POT;
                else if (pick < 86)
                    cmd = MODE_FAST;
                else if (pick < 90)
                    cmd = MODE_MID;
                else if (pick < 95)
                    cmd = MODE_SLOW;
                else
                    cmd = ModeW'($urandom_range(ModeUnusedLo, ModeUnusedHi));
                queue_command(cmd, FuncW'($urandom_range(0, 255)),
                              AdcW'($urandom_range(0, 4095)));
                added++;
            end
        end
    endfunction

    // Waits until every command has gone in and every status has come back.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_cmds.size() != 0 || in_valid || expected_status.size() != 0);
        repeat (DrainCycles) @(posedge clk);
    endtask

    // Writes all three registers while the block is idle.
    task automatic apply_setting(logic [StepW-1:0] step_val, logic [DelayW-1:0] min_val,
                                 logic [DelayW-1:0] max_val);
        wait_drained();
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_SLEW_STEP;
        cfg_data <= CfgW'(step_val);
        @(posedge clk);
        cfg_index <= CFG_MIN_TARGET;
        cfg_data <= min_val;
        @(posedge clk);
        cfg_index <= CFG_MAX_TARGET;
        cfg_data <= max_val;
        @(posedge clk);
        cfg_we <= 1'b0;
        ctl_cfg = '{step_val, min_val, max_val};
        n_settings++;
        @(negedge clk);
    endtask

    // Input driver: predicts each accepted item, then presents the next after its pause.
    always @(posedge clk or negedge rst_n)
    begin : driver
        command_t next_cmd;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            mode <= '0;
            value <= '0;
            adc_sample <= '0;
            send_wait <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_status.push_back(apply_command({mode, value, adc_sample}));
                n_items++;
                if (mode == MODE_TICK)
                    n_ticks++;
            end
            if (!in_valid || !in_stall)
            begin
                if (send_wait != 0)
                begin
                    in_valid <= 1'b0;
                    send_wait <= send_wait - 1;
                end
                else if (pending_cmds.size() != 0)
                begin
                    next_cmd = pending_cmds.pop_front();
                    mode <= next_cmd.mode;
                    value <= next_cmd.value;
                    adc_sample <= next_cmd.adc;
                    in_valid <= 1'b1;
                    send_wait <= draw_pause(send_calm);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: checks each accepted status item and stalls at random.
    always @(posedge clk or negedge rst_n)
    begin : monitor
        status_t     want;
        int unsigned pause_len;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_wait <= 0;
        end
        else if (out_valid && !out_stall)
        begin
            if (expected_status.size() == 0)
            begin
                $error("status item arrived with no command outstanding");
                n_errors++;
            end
            else
            begin
                want = expected_status.pop_front();
                n_checked++;
                compare_field("current_delay", want.current_delay, current_delay);
                compare_field("target_delay", want.target_delay, target_delay);
                compare_field("active_function", want.active_function, active_function);
                compare_field("sound_enabled", want.sound, sound_enabled);
                compare_field("smoothing_enabled", want.smoothing, smoothing_enabled);
                compare_field("function_changed", want.changed, function_changed);
            end
            pause_len = draw_pause(recv_calm);
            hold_wait <= pause_len;
            out_stall <= (pause_len != 0);
        end
        else if (hold_wait != 0)
        begin
            hold_wait <= hold_wait - 1;
            out_stall <= (hold_wait > 1);
        end
    end

    initial
    begin : stimulus
        ctl_state = '{DefaultDelay, DefaultDelay, '0, 1'b1, 1'b1};
        ctl_cfg = '{SlewStepRst, MinTargetRst, MaxTargetRst};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed commands under the reset register values.
        queue_command(MODE_TICK, '0, '0);
        queue_command(MODE_SET_FUNC, '1, '0);
        queue_command(MODE_SET_FUNC, '0, '1);
        queue_command(MODE_SOUND, '0, '0);
        queue_command(MODE_SOUND, '0, '0);
        queue_command(MODE_SLOW, '0, '0);
        queue_command(MODE_TICK, '0, '0);
        // Doubling the largest preset runs into the cap.
        queue_command(MODE_DOWN, '0, '0);
        queue_command(MODE_TICK, '0, '0);
        queue_command(MODE_FAST, '0, '0);
        queue_command(MODE_UP, '0, '0);
        queue_command(MODE_UP, '0, '0);
        // The third halving falls below the floor.
        queue_command(MODE_UP, '0, '0);
        queue_command(MODE_TICK, '0, '0);
        queue_command(MODE_POT, '0, '0);
        // Smoothing is off after a pot command, so this tick changes nothing.
        queue_command(MODE_TICK, '0, '0);
        queue_command(MODE_POT, '0, '1);
        queue_command(MODE_DOWN, '0, '0);
        queue_command(ModeUnusedLo, '1, '1);
        queue_command(ModeUnusedHi, '0, '0);
        // A pot delay of 520 sits within one step of 500, so the tick must not overshoot.
        queue_command(MODE_POT, '0, AdcW'(906));
        queue_command(MODE_DEFAULT, '0, '0);
        queue_command(MODE_TICK, '0, '0);
        queue_command(MODE_MID, '0, '0);
        queue_command(MODE_SET_FUNC, 8'h5A, '0);

        // Largest step with the widest target range.
        apply_setting(StepW'(1000), DelayW'(1), DelayW'(10000));
        queue_random(PhaseItems);
        // Floor above the cap, with a step of one.
        apply_setting(StepW'(1), DelayW'(10000), DelayW'(1));
        queue_random(PhaseItems);
        // A zero step leaves the current delay where it is.
        apply_setting(StepW'(0), DelayW'(200), DelayW'(3000));
        queue_random(PhaseItems);
        for (int p = 0; p < 3; p++)
        begin
            apply_setting(StepW'($urandom_range(1, 1000)), DelayW'($urandom_range(1, 10000)),
                          DelayW'($urandom_range(1, 10000)));
            queue_random(PhaseItems);
        end
        wait_drained();

        $display("Drove %0d commands (%0d of them ticks) over %0d register settings.",
                 n_items, n_ticks, n_settings + 1);
        $display("Compared %0d status items, %0d mismatches.", n_checked, n_errors);
        if (n_errors == 0)
            $display("PASS speed_command_slew_controller");
        else
            $display("FAIL speed_command_slew_controller");
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #5000000;
        $display("FAIL speed_command_slew_controller");
        $finish;
    end

endmodule
